>>> hw/rtl/irc_pkg.sv
// Shared constants, types and state encodings of the integer rate changer.
`default_nettype none

package irc_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_FACTOR   = 64;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_FACTOR = 1'b1;

  localparam logic [CFG_DATA_W-1:0] RATE_FACTOR_RESET = 7'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_LOAD,
    ST_WAIT,
    ST_EMIT
  } irc_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_NEG,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  // Requests from the controller to the serial divider.
  typedef struct packed {
    logic start;
    logic ack;
  } div_ctl_t;

  // Status from the serial divider back to the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/integer_rate_changer_core.sv
// Top level of the integer rate changer: hold upsampler and block averager.
//
// Usage: samples enter on the s_axis channel (tdata = in_sample, tlast = end of
// wave) and results leave on the m_axis channel (tdata = out_sample, tlast =
// last result caused by that input). Registers are written through the cfg
// channel (index 0 = slow_mode, index 1 = rate_factor); the user must write
// them only while the block is idle, which the block itself does not enforce.
// In slow mode every sample yields rate_factor beats, one per cycle while the
// receiver accepts them, the first after the EMIT state loads the output
// register. In fast mode an input beat passes bit-serially through the
// accumulator; a beat that closes a block adds the serial divider's sign pass
// and quotient pass. An incomplete block at the end of a wave is dropped
// without an accumulator pass. The output register frees the input side: the next
// sample is accepted while a finished result still waits. When the receiver
// stalls, the pending beat holds and the block waits before it loads another one.
// Reset is asynchronous: slow_mode returns to 0, rate_factor to 1, and the open
// block is cleared; no clearing pass is needed.
`default_nettype none

module integer_rate_changer_core
  import irc_pkg::*;
#(
  parameter int MAX_FACTOR   = DEF_MAX_FACTOR,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input samples.
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  input  wire logic [TDW-1:0]        s_axis_tdata_i,  // [SAMPLE_WIDTH-1:0] in_sample, rest zero
  input  wire logic                  s_axis_tlast_i,  // wave_end
  // Results.
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output      logic [TDW-1:0]        m_axis_tdata_o,  // [SAMPLE_WIDTH-1:0] out_sample, rest zero
  output      logic                  m_axis_tlast_o,  // run_last
  // Register writes.
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int SUMW = SAMPLE_WIDTH + $clog2(MAX_FACTOR);
  localparam int FW   = $clog2(MAX_FACTOR + 1);
  localparam int CW   = $clog2(MAX_FACTOR);
  localparam int BCW  = $clog2(SUMW);

  irc_state_e state_q, state_d;

  logic                  slow_mode_q;
  logic [CFG_DATA_W-1:0] rate_q;

  logic [SUMW-1:0] sum_q;
  logic [SUMW-1:0] add_q;
  logic            carry_q;
  logic [CW-1:0]   count_q;
  logic [BCW-1:0]  bit_cnt_q;
  logic            close_q;
  logic [SW-1:0]   smp_q;
  logic [FW-1:0]   rep_q;

  logic            out_valid_q;
  logic [SW-1:0]   out_data_q;
  logic            out_last_q;

  logic [FW-1:0]   eff_f;
  logic [SW-1:0]   in_sample;
  logic            in_fire;
  logic [CW:0]     cnt_next;
  logic            blk_close;
  logic            bit_last;
  logic            sum_bit;
  logic            carry_d;
  logic            slot_free;
  logic            emit_load;
  logic            div_load;

  div_ctl_t        div_ctl;
  div_stat_t       div_stat;
  logic [SW-1:0]   div_quot;

  // A factor of zero acts as one, and anything above the limit as the limit.
  always_comb begin
    priority if (rate_q == '0) begin
      eff_f = FW'(1);
    end else if (rate_q > MAX_FACTOR) begin
      eff_f = FW'(MAX_FACTOR);
    end else begin
      eff_f = FW'(rate_q);
    end
  end

  assign in_sample = s_axis_tdata_i[SW-1:0];
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_next  = (CW+1)'(count_q) + (CW+1)'(1);
  assign blk_close = (cnt_next >= eff_f);

  // One full-adder cell; the sum register rotates through it LSB first.
  assign bit_last = (bit_cnt_q == BCW'(SUMW - 1));
  assign sum_bit  = sum_q[0] ^ add_q[0] ^ carry_q;
  assign carry_d  = (sum_q[0] & add_q[0]) | (carry_q & (sum_q[0] ^ add_q[0]));

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign emit_load = (state_q == ST_EMIT) && slot_free;
  assign div_load  = (state_q == ST_WAIT) && div_stat.done && slot_free;

  assign div_ctl.start = (state_q == ST_LOAD);
  assign div_ctl.ack   = div_load;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDW'(out_data_q);
  assign m_axis_tlast_o  = out_last_q;

  irc_sdiv #(
    .MAX_FACTOR  (MAX_FACTOR),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_sdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (div_ctl),
    .dividend_i(sum_q),
    .divisor_i (eff_f),
    .stat_o    (div_stat),
    .quotient_o(div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (slow_mode_q) begin
            state_d = ST_EMIT;
          end else if (blk_close || !s_axis_tlast_i) begin
            state_d = ST_ADD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ADD: begin
        if (bit_last) begin
          state_d = close_q ? ST_LOAD : ST_IDLE;
        end
      end
      ST_LOAD: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_load && rep_q == FW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slow_mode_q <= 1'b0;
      rate_q      <= RATE_FACTOR_RESET;
      sum_q       <= '0;
      count_q     <= '0;
      bit_cnt_q   <= '0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SLOW_MODE:   slow_mode_q <= cfg_data_i[0];
          CFG_RATE_FACTOR: rate_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        bit_cnt_q <= '0;
        priority if (slow_mode_q) begin
          rep_q   <= eff_f;
          sum_q   <= '0;
          count_q <= '0;
        end else if (blk_close) begin
          count_q <= '0;
        end else if (s_axis_tlast_i) begin
          // The wave ended inside an open block: drop it.
          sum_q   <= '0;
          count_q <= '0;
        end else begin
          count_q <= cnt_next[CW-1:0];
        end
      end

      if (state_q == ST_ADD) begin
        sum_q     <= {sum_bit, sum_q[SUMW-1:1]};
        bit_cnt_q <= bit_cnt_q + BCW'(1);
      end

      // The divider latches the block sum in this cycle.
      if (state_q == ST_LOAD) begin
        sum_q <= '0;
      end

      if (emit_load) begin
        rep_q <= rep_q - FW'(1);
      end

      if (emit_load || div_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q   <= in_sample;
      add_q   <= {{(SUMW-SW){in_sample[SW-1]}}, in_sample};
      carry_q <= 1'b0;
      close_q <= blk_close;
    end
    if (state_q == ST_ADD) begin
      add_q   <= {add_q[SUMW-1], add_q[SUMW-1:1]};
      carry_q <= carry_d;
    end
    if (emit_load) begin
      out_data_q <= smp_q;
      out_last_q <= (rep_q == FW'(1));
    end else if (div_load) begin
      out_data_q <= div_quot;
      out_last_q <= 1'b1;
    end
  end

  a_fast_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !slow_mode_q) |-> m_axis_tlast_o)
    else $error("averaged result without last marker");

  a_div_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_WAIT)
    else $error("divider result while controller not waiting");

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_stat.busy && close_q)
    else $error("divider started while busy or without a closed block");

  a_slow_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && slow_mode_q) |=> sum_q == '0 && count_q == '0)
    else $error("block state not cleared by a slow mode sample");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> rep_q != '0)
    else $error("repeat counter empty while emitting");

endmodule

`default_nettype wire

>>> hw/rtl/irc_sdiv.sv
// Bit-serial signed divider with truncation toward zero and saturation to the sample range.
`default_nettype none

module irc_sdiv
  import irc_pkg::*;
#(
  parameter int MAX_FACTOR   = DEF_MAX_FACTOR,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int SUMW = SAMPLE_WIDTH + $clog2(MAX_FACTOR),
  localparam int FW   = $clog2(MAX_FACTOR + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire div_ctl_t                ctl_i,
  input  wire logic [SUMW-1:0]         dividend_i,
  input  wire logic [FW-1:0]           divisor_i,
  output      div_stat_t               stat_o,
  output      logic [SAMPLE_WIDTH-1:0] quotient_o
);

  localparam int BCW = $clog2(SUMW);
  localparam int SW  = SAMPLE_WIDTH;

  div_state_e state_q, state_d;

  logic [SUMW-1:0] dvd_q;
  logic [FW-1:0]   div_q;
  logic [FW-1:0]   rem_q;
  logic [BCW-1:0]  cnt_q;
  logic            neg_q;
  logic            seen_q;

  logic            cnt_last;
  logic            neg_bit;
  logic [FW:0]     rem_sh;
  logic            rem_ge;
  logic [FW-1:0]   rem_sub;
  logic            ovf_pos;
  logic            ovf_neg;

  assign cnt_last = (cnt_q == BCW'(SUMW - 1));

  // Serial two's complement negation: invert every bit after the first one.
  assign neg_bit = dvd_q[0] ^ (neg_q & seen_q);

  // One restoring step: shift the next dividend bit into the remainder.
  // The difference is below the divisor whenever it is taken, so its low bits suffice.
  assign rem_sh  = {rem_q, dvd_q[SUMW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_q});
  assign rem_sub = rem_sh[FW-1:0] - div_q;

  // The magnitude can exceed the sample range when the factor was lowered mid-block.
  assign ovf_pos = |dvd_q[SUMW-1:SW-1];
  assign ovf_neg = (|dvd_q[SUMW-1:SW]) || (dvd_q[SW-1] && (|dvd_q[SW-2:0]));

  always_comb begin
    priority if (!neg_q && ovf_pos) begin
      quotient_o = {1'b0, {(SW-1){1'b1}}};
    end else if (neg_q && ovf_neg) begin
      quotient_o = {1'b1, {(SW-1){1'b0}}};
    end else if (neg_q) begin
      quotient_o = SW'(0) - dvd_q[SW-1:0];
    end else begin
      quotient_o = dvd_q[SW-1:0];
    end
  end

  assign stat_o.busy = (state_q != DIV_IDLE);
  assign stat_o.done = (state_q == DIV_DONE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (ctl_i.start) begin
          state_d = DIV_NEG;
        end
      end
      DIV_NEG: begin
        if (cnt_last) begin
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt_last) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (ctl_i.ack) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_NEG || state_q == DIV_RUN) begin
        cnt_q <= cnt_last ? '0 : cnt_q + BCW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DIV_IDLE: begin
        if (ctl_i.start) begin
          dvd_q  <= dividend_i;
          div_q  <= divisor_i;
          neg_q  <= dividend_i[SUMW-1];
          seen_q <= 1'b0;
        end
      end
      DIV_NEG: begin
        dvd_q  <= {neg_bit, dvd_q[SUMW-1:1]};
        seen_q <= seen_q | dvd_q[0];
        rem_q  <= '0;
      end
      DIV_RUN: begin
        dvd_q <= {dvd_q[SUMW-2:0], rem_ge};
        rem_q <= rem_ge ? rem_sub : rem_sh[FW-1:0];
      end
      DIV_DONE: begin
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> state_q == DIV_IDLE)
    else $error("divider started while busy");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV_RUN) |-> rem_q < div_q)
    else $error("partial remainder not below divisor");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_o.done && !ctl_i.ack) |=> stat_o.done && $stable(quotient_o))
    else $error("quotient dropped before acknowledge");

endmodule

`default_nettype wire
